>>> rtl/core/kbq_pkg.sv
// ----------------------------------------------------------------------------
// kbq_pkg
// Shared types, constants and helper functions for the keyboard event queue.
// ----------------------------------------------------------------------------
package kbq_pkg;

  localparam int unsigned KeyCountDef    = 256;
  localparam int unsigned RingDepthDef   = 16;
  localparam int unsigned FilterDepthDef = 64;

  localparam int unsigned OpW  = 3;
  localparam int unsigned KeyW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned CntW = 16;
  localparam int unsigned FidxW = 6;
  localparam int unsigned FcntW = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // s_axis tdata: opcode, key_code, key_make, stamp_ms, filter_index, filter_value
  localparam int unsigned InDataW = 72;
  // m_axis tdata: key_word, key_time, edge_count, queue_nonempty, accepted
  localparam int unsigned OutDataW = 72;

  typedef enum logic [2:0] {
    OP_KEY     = 3'd0,
    OP_POP     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_RD_DOWN = 3'd3,
    OP_RD_UP   = 3'd4,
    OP_FLUSH   = 3'd5,
    OP_FWRITE  = 3'd6,
    OP_FCLEAR  = 3'd7
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_REPEAT = 2'd0,
    CFG_LAYOUT = 2'd1,
    CFG_FCOUNT = 2'd2,
    CFG_DEBUG  = 2'd3
  } cfg_reg_e;

  localparam logic [KeyW-1:0] ScLShift = 8'h2A;
  localparam logic [KeyW-1:0] ScRShift = 8'h36;
  localparam logic [KeyW-1:0] ScLAlt   = 8'h38;
  localparam logic [KeyW-1:0] ScRAlt   = 8'hB8;
  localparam logic [KeyW-1:0] ScLCtrl  = 8'h1D;
  localparam logic [KeyW-1:0] ScRCtrl  = 8'h9D;
  localparam logic [KeyW-1:0] ScDebug  = 8'h29;
  localparam logic [KeyW-1:0] ScNoBuf  = 8'hAA;
  localparam logic [CntW-1:0] CntMax   = 16'hFFFF;
  localparam logic [WordW-1:0] FilterReset = 16'hFFFF;

  // Scan-code folding followed by the layout remap.
  function automatic logic [KeyW-1:0] remap_code(input logic [KeyW-1:0] code,
                                                 input logic [1:0] mode);
    logic [KeyW-1:0] c;
    c = code;
    if (c == 8'h56) c = 8'h2B;
    if (c == ScRShift) c = ScLShift;
    if (c == ScRAlt) c = ScLAlt;
    if (mode == 2'd1) begin
      case (c)
        8'h1E: c = 8'h10;
        8'h32: c = 8'h33;
        8'h10: c = 8'h1E;
        8'h11: c = 8'h2C;
        8'h2C: c = 8'h11;
        8'h27: c = 8'h32;
        8'h33: c = 8'h27;
        default: c = c;
      endcase
    end else if (mode == 2'd2) begin
      if (c == 8'h15) c = 8'h2C;
      else if (c == 8'h2C) c = 8'h15;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/kbq_filter.sv
// ----------------------------------------------------------------------------
// kbq_filter
// Filter table memory with a sequential match scan and a clearing sweep.
// ----------------------------------------------------------------------------
module kbq_filter import kbq_pkg::*; #(
  parameter int unsigned FilterDepth = FilterDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [FidxW-1:0] wr_idx_i,
  input  logic [WordW-1:0] wr_val_i,
  input  logic             clr_start_i,
  output logic             clr_busy_o,
  input  logic             scan_start_i,
  input  logic [FcntW-1:0] scan_lim_i,
  input  logic [WordW-1:0] scan_word_i,
  output logic             scan_done_o,
  output logic             scan_hit_o
);
  localparam int unsigned AW = (FilterDepth > 1) ? $clog2(FilterDepth) : 1;
  localparam int unsigned CW = $clog2(FilterDepth + 1);

  logic [WordW-1:0] mem_q [FilterDepth];
  logic [WordW-1:0] rd_q;
  logic [CW-1:0] ptr_q;
  logic [CW-1:0] lim_q;
  logic          scan_q, chk_q, clr_q, hit_q, done_q;
  logic [AW-1:0] clr_addr;
  logic          clr_last;

  assign clr_addr = ptr_q[AW-1:0];
  assign clr_last = (ptr_q == CW'(FilterDepth - 1));
  assign clr_busy_o = clr_q;
  assign scan_done_o = done_q;
  assign scan_hit_o = hit_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr] <= FilterReset;
    end else if (wr_en_i && (32'(wr_idx_i) < FilterDepth)) begin
      mem_q[AW'(wr_idx_i)] <= wr_val_i;
    end
    rd_q <= mem_q[ptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0; lim_q <= '0; scan_q <= 1'b0; chk_q <= 1'b0;
      clr_q <= 1'b1; hit_q <= 1'b0; done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      chk_q  <= 1'b0;
      if (clr_q) begin
        ptr_q <= clr_last ? '0 : ptr_q + 1'b1;
        if (clr_last) clr_q <= 1'b0;
      end else if (clr_start_i) begin
        clr_q <= 1'b1;
        ptr_q <= '0;
      end else if (scan_start_i) begin
        ptr_q <= '0;
        hit_q <= (scan_lim_i == '0);
        if (32'(scan_lim_i) >= FilterDepth) lim_q <= CW'(FilterDepth);
        else lim_q <= CW'(scan_lim_i);
        if (scan_lim_i == '0) done_q <= 1'b1;
        else scan_q <= 1'b1;
      end else if (scan_q) begin
        // rd_q is the entry addressed in the previous cycle
        if (chk_q && rd_q == scan_word_i) begin
          hit_q <= 1'b1; scan_q <= 1'b0; done_q <= 1'b1;
        end else if (ptr_q == lim_q) begin
          if (chk_q) begin
            scan_q <= 1'b0; done_q <= 1'b1;
          end else begin
            chk_q <= 1'b0;
          end
        end else begin
          ptr_q <= ptr_q + 1'b1;
          chk_q <= 1'b1;
        end
      end
    end
  end
endmodule

>>> rtl/core/keyboard_event_queue_top.sv
// ----------------------------------------------------------------------------
// keyboard_event_queue_top
// Keyboard event queue with modifier tags, edge counters, filter and ring.
// ----------------------------------------------------------------------------
// Usage: commands enter on s_axis (one transaction per command), one result
// leaves on m_axis per command. Registers are written through cfg_valid_i /
// cfg_ready_o with cfg_addr_i selecting repeat_enable, layout_mode,
// filter_count or debug_tag_enable; the user must write them only while no
// command is in flight, which the block itself does not enforce.
// A scanned press compares up to min(filter_count, FilterDepth) filter
// entries through the single filter memory read port, which visits one entry
// per cycle. A filter clear sweeps the filter memory, a flush sweeps the
// counter memories. The block returns to idle after each result before it
// takes the next command.
// After reset the filter memory is swept to all ones and the counter
// memories are cleared one key a cycle; no command is accepted meanwhile
// and no result is produced.
// The result sits in an output register; a stalled receiver holds it and
// the block takes no new command until it is taken.
// ----------------------------------------------------------------------------
module keyboard_event_queue_top import kbq_pkg::*; #(
  parameter int unsigned KeyCount    = KeyCountDef,
  parameter int unsigned RingDepth   = RingDepthDef,
  parameter int unsigned FilterDepth = FilterDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [2:0] opcode, [10:3] key_code, [11] key_make, [43:12] stamp_ms,
  // [49:44] filter_index, [65:50] filter_value
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] key_word, [47:16] key_time, [63:48] edge_count,
  // [64] queue_nonempty, [65] accepted
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  localparam int unsigned KW = $clog2(KeyCount);
  localparam int unsigned KCW = $clog2(KeyCount + 1);
  localparam int unsigned RW = $clog2(RingDepth);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_RD    = 9'b000000010,
    ST_MOD   = 9'b000000100,
    ST_CNT   = 9'b000001000,
    ST_SCAN  = 9'b000010000,
    ST_WAIT  = 9'b000100000,
    ST_SWEEP = 9'b001000000,
    ST_FCLR  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  state_e state_q;
  logic   boot_q;

  // config
  logic repeat_q, debug_en_q;
  logic [1:0] layout_q;
  logic [FcntW-1:0] fcount_q;

  // latched command
  logic [OpW-1:0]   op_q;
  logic [KeyW-1:0]  code_q;
  logic             down_q;
  logic [TimeW-1:0] time_q;
  logic [KW-1:0]    sc_q;
  logic [WordW-1:0] word_q;

  // key state: pressed bits in flops, counters in memories
  logic [KeyCount-1:0] pressed_q;
  logic [CntW-1:0] dcnt_mem [KeyCount];
  logic [CntW-1:0] ucnt_mem [KeyCount];
  logic [CntW-1:0] dcnt_rd_q, ucnt_rd_q;
  logic [KCW-1:0]  sweep_q;

  logic [WordW-1:0] key_ring [RingDepth];
  logic [TimeW-1:0] time_ring [RingDepth];
  logic [WordW-1:0] ring_key_rd_q;
  logic [TimeW-1:0] ring_time_rd_q;
  logic [RW-1:0] head_q, tail_q;

  // output register
  logic [WordW-1:0] o_word_q;
  logic [TimeW-1:0] o_time_q;
  logic [CntW-1:0]  o_cnt_q;
  logic             o_acc_q;

  logic in_fire;
  logic [KW-1:0] sc_in;
  logic [KeyW-1:0] rm;
  logic [RW-1:0] tail_nx, head_nx;
  logic [WordW-1:0] tag_word;
  logic ring_we;
  logic [KW-1:0] cnt_addr;
  logic [CntW-1:0] dcnt_wd, ucnt_wd;
  logic dcnt_we, ucnt_we;
  logic f_wr, f_clr, f_scan, f_busy, f_done, f_hit;
  logic in_range;

  assign s_axis_tready = (state_q == ST_IDLE) && !f_busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = {6'b0, o_acc_q, (head_q != tail_q), o_cnt_q, o_time_q, o_word_q};

  assign rm = remap_code(s_axis_tdata[10:3], layout_q);
  assign sc_in = rm[KW-1:0];
  assign in_range = ({1'b0, code_q} < 9'(KeyCount));
  assign tail_nx = (tail_q == RW'(RingDepth - 1)) ? '0 : tail_q + 1'b1;
  assign head_nx = (head_q == RW'(RingDepth - 1)) ? '0 : head_q + 1'b1;

  always_comb begin
    tag_word = WordW'(sc_q);
    if (pressed_q[ScLShift[KW-1:0]] || (9'(ScRShift) < 9'(KeyCount) && pressed_q[ScRShift[KW-1:0]]))
      tag_word[12] = 1'b1;
    if (pressed_q[ScLAlt[KW-1:0]] || (9'(ScRAlt) < 9'(KeyCount) && pressed_q[ScRAlt[KW-1:0]]))
      tag_word[13] = 1'b1;
    if (pressed_q[ScLCtrl[KW-1:0]] || (9'(ScRCtrl) < 9'(KeyCount) && pressed_q[ScRCtrl[KW-1:0]]))
      tag_word[14] = 1'b1;
    if (debug_en_q && pressed_q[ScDebug[KW-1:0]]) tag_word[15] = 1'b1;
  end

  // counter memory write port: sweep or single update
  always_comb begin
    // counter reads address the raw key code, key events the remapped one
    cnt_addr = (op_q inside {OP_RD_DOWN, OP_RD_UP}) ? code_q[KW-1:0] : sc_q;
    dcnt_we = 1'b0; ucnt_we = 1'b0;
    dcnt_wd = '0;   ucnt_wd = '0;
    if (state_q == ST_SWEEP) begin
      cnt_addr = sweep_q[KW-1:0];
      dcnt_we = 1'b1; ucnt_we = 1'b1;
    end else if (state_q == ST_CNT) begin
      if (op_q == OP_KEY) begin
        if (!down_q) begin
          ucnt_we = 1'b1;
          ucnt_wd = (ucnt_rd_q == CntMax) ? CntMax : ucnt_rd_q + 1'b1;
        end else if (!pressed_q[sc_q]) begin
          dcnt_we = 1'b1;
          dcnt_wd = (dcnt_rd_q == CntMax) ? CntMax : dcnt_rd_q + 1'b1;
        end
      end else if (in_range) begin
        cnt_addr = code_q[KW-1:0];
        dcnt_we = (op_q == OP_RD_DOWN);
        ucnt_we = (op_q == OP_RD_UP);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dcnt_we) dcnt_mem[cnt_addr] <= dcnt_wd;
    if (ucnt_we) ucnt_mem[cnt_addr] <= ucnt_wd;
    dcnt_rd_q <= dcnt_mem[cnt_addr];
    ucnt_rd_q <= ucnt_mem[cnt_addr];
  end

  assign ring_we = (state_q == ST_WAIT) && f_done && f_hit;
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      key_ring[tail_q]  <= word_q;
      time_ring[tail_q] <= time_q;
    end
    ring_key_rd_q  <= key_ring[head_q];
    ring_time_rd_q <= time_ring[head_q];
  end

  assign f_wr   = (state_q == ST_RD) && (op_q == OP_FWRITE);
  assign f_clr  = (state_q == ST_RD) && (op_q == OP_FCLEAR);
  assign f_scan = (state_q == ST_SCAN);

  kbq_filter #(.FilterDepth(FilterDepth)) u_filter (
    .clk_i, .rst_ni,
    .wr_en_i(f_wr), .wr_idx_i(time_q[FidxW-1:0]), .wr_val_i(word_q),
    .clr_start_i(f_clr), .clr_busy_o(f_busy),
    .scan_start_i(f_scan), .scan_lim_i(fcount_q), .scan_word_i(word_q),
    .scan_done_o(f_done), .scan_hit_o(f_hit)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= s_axis_tdata[2:0];
      code_q <= s_axis_tdata[10:3];
      down_q <= s_axis_tdata[11];
      sc_q   <= sc_in;
      // filter writes reuse the time and word registers for index and value
      if (s_axis_tdata[2:0] == OP_FWRITE) begin
        time_q <= TimeW'(s_axis_tdata[49:44]);
        word_q <= s_axis_tdata[65:50];
      end else begin
        time_q <= s_axis_tdata[43:12];
        word_q <= '0;
      end
    end else if (state_q == ST_MOD) begin
      word_q <= tag_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      boot_q <= 1'b1;
      sweep_q <= '0;
      repeat_q <= 1'b1; layout_q <= '0; fcount_q <= '0; debug_en_q <= 1'b1;
      pressed_q <= '0; head_q <= '0; tail_q <= '0;
      o_word_q <= '0; o_time_q <= '0; o_cnt_q <= '0; o_acc_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          CFG_REPEAT: repeat_q   <= cfg_data_i[0];
          CFG_LAYOUT: layout_q   <= cfg_data_i[1:0];
          CFG_FCOUNT: fcount_q   <= cfg_data_i[FcntW-1:0];
          CFG_DEBUG:  debug_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: if (in_fire) state_q <= ST_RD;
        ST_RD: begin
          o_word_q <= '0; o_time_q <= '0; o_cnt_q <= '0; o_acc_q <= 1'b0;
          case (op_q)
            OP_KEY, OP_RD_DOWN, OP_RD_UP, OP_POP, OP_PEEK: state_q <= ST_CNT;
            OP_FLUSH: begin
              head_q <= '0; tail_q <= '0; pressed_q <= '0;
              sweep_q <= '0; state_q <= ST_SWEEP;
            end
            OP_FCLEAR: begin
              fcount_q <= '0; state_q <= ST_FCLR;
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_CNT: begin
          state_q <= ST_OUT;
          case (op_q)
            OP_KEY: begin
              if (!down_q) begin
                pressed_q[sc_q] <= 1'b0;
              end else if (!pressed_q[sc_q] || repeat_q) begin
                pressed_q[sc_q] <= 1'b1;
                if (KCW'(sc_q) != KCW'(ScNoBuf)) state_q <= ST_MOD;
              end
            end
            OP_RD_DOWN: o_cnt_q <= in_range ? dcnt_rd_q : '0;
            OP_RD_UP:   o_cnt_q <= in_range ? ucnt_rd_q : '0;
            OP_POP: if (head_q != tail_q) begin
              o_word_q <= ring_key_rd_q; o_time_q <= ring_time_rd_q;
              head_q <= head_nx;
            end
            OP_PEEK: if (head_q != tail_q) o_word_q <= ring_key_rd_q;
            default: ;
          endcase
        end
        ST_MOD: begin
          if (tag_word == '0 || tail_nx == head_q) state_q <= ST_OUT;
          else state_q <= ST_SCAN;
        end
        ST_SCAN: state_q <= ST_WAIT;
        ST_WAIT: if (f_done) begin
          if (f_hit) begin
            tail_q <= tail_nx; o_acc_q <= 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_SWEEP: begin
          // the sweep after reset ends without a result
          if (sweep_q == KCW'(KeyCount - 1)) begin
            state_q <= boot_q ? ST_IDLE : ST_OUT;
            boot_q <= 1'b0;
          end else begin
            sweep_q <= sweep_q + 1'b1;
          end
        end
        ST_FCLR: if (!f_busy) state_q <= ST_OUT;
        ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (tail_nx != head_q))
    else $error("ring write while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> (state_q == ST_IDLE))
    else $error("result not retired");
endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyboard event queue: directed commands, then
// random phases under several register settings. Each result is checked
// against a built-in predictor or, for some directed ones, a fixed value.
// ----------------------------------------------------------------------------
module tb import kbq_pkg::*;;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [TimeW-1:0] ktime;
    logic [CntW-1:0]  cnt;
    logic             nonempty;
    logic             acc;
  } kbq_res_t;

  typedef struct {
    opcode_e          op;
    logic [KeyW-1:0]  code;
    logic             dn;
    logic [TimeW-1:0] t;
    logic [FidxW-1:0] fidx;
    logic [WordW-1:0] fval;
    bit               fixed;
    kbq_res_t         res;
  } kbq_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  keyboard_event_queue_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  bit               held_map [KeyCountDef];
  logic [CntW-1:0]  make_cnt [KeyCountDef];
  logic [CntW-1:0]  break_cnt [KeyCountDef];
  logic [WordW-1:0] ring_word [RingDepthDef];
  logic [TimeW-1:0] ring_time [RingDepthDef];
  logic [3:0]       rd_ptr, wr_ptr;
  logic [WordW-1:0] accept_tab [FilterDepthDef];
  logic             rpt_en, dbg_en;
  logic [1:0]       layout;
  logic [FcntW-1:0] flt_cnt;

  kbq_res_t result_q[$];
  int       errors = 0;
  bit       quiet = 1'b0;

  logic [KeyW-1:0] hot_codes [22] = '{8'h2A, 8'h36, 8'h38, 8'hB8, 8'h1D, 8'h9D, 8'h29,
    8'hAA, 8'h56, 8'h2B, 8'h1E, 8'h10, 8'h32, 8'h33, 8'h11, 8'h2C, 8'h27, 8'h15,
    8'h00, 8'hFF, 8'h01, 8'h80};

  function automatic logic [KeyW-1:0] fold_code(logic [KeyW-1:0] c);
    if (c == 8'h56) c = 8'h2B;
    if (c == ScRShift) c = ScLShift;
    if (c == ScRAlt) c = ScLAlt;
    if (layout == 2'd1) begin
      case (c)
        8'h1E: return 8'h10;
        8'h32: return 8'h33;
        8'h10: return 8'h1E;
        8'h11: return 8'h2C;
        8'h2C: return 8'h11;
        8'h27: return 8'h32;
        8'h33: return 8'h27;
        default: return c;
      endcase
    end else if (layout == 2'd2) begin
      if (c == 8'h15) return 8'h2C;
      if (c == 8'h2C) return 8'h15;
    end
    return c;
  endfunction

  function automatic void clear_queue_state();
    rd_ptr = '0;
    wr_ptr = '0;
    for (int i = 0; i < RingDepthDef; i++) begin
      ring_word[i] = '0;
      ring_time[i] = '0;
    end
    for (int i = 0; i < KeyCountDef; i++) begin
      held_map[i] = 1'b0;
      make_cnt[i] = '0;
      break_cnt[i] = '0;
    end
  endfunction

  function automatic void clear_accept_tab();
    for (int i = 0; i < FilterDepthDef; i++) accept_tab[i] = FilterReset;
    flt_cnt = '0;
  endfunction

  function automatic logic enqueue_key(logic [KeyW-1:0] code, logic dn, logic [TimeW-1:0] t);
    logic [KeyW-1:0]  sc;
    logic [WordW-1:0] w;
    int               lim;
    bit               ok;
    sc = fold_code(code);
    if (!dn) begin
      held_map[sc] = 1'b0;
      if (break_cnt[sc] != CntMax) break_cnt[sc]++;
      return 1'b0;
    end
    if (!held_map[sc]) begin
      held_map[sc] = 1'b1;
      if (make_cnt[sc] != CntMax) make_cnt[sc]++;
    end else if (!rpt_en) begin
      return 1'b0;
    end
    if (sc == ScNoBuf) return 1'b0;
    w = {8'h00, sc};
    if (held_map[ScLShift] || held_map[ScRShift]) w[12] = 1'b1;
    if (held_map[ScLAlt] || held_map[ScRAlt]) w[13] = 1'b1;
    if (held_map[ScLCtrl] || held_map[ScRCtrl]) w[14] = 1'b1;
    if (dbg_en && held_map[ScDebug]) w[15] = 1'b1;
    if (w == '0) return 1'b0;
    if (wr_ptr + 4'd1 == rd_ptr) return 1'b0;
    lim = (flt_cnt < FilterDepthDef) ? flt_cnt : FilterDepthDef;
    ok = (lim == 0);
    for (int i = 0; i < lim; i++) if (accept_tab[i] == w) ok = 1'b1;
    if (!ok) return 1'b0;
    ring_word[wr_ptr] = w;
    ring_time[wr_ptr] = t;
    wr_ptr++;
    return 1'b1;
  endfunction

  function automatic kbq_res_t predict_result(kbq_cmd_t c);
    kbq_res_t r;
    r = '0;
    case (c.op)
      OP_KEY: r.acc = enqueue_key(c.code, c.dn, c.t);
      OP_POP: if (rd_ptr != wr_ptr) begin
        r.word = ring_word[rd_ptr];
        r.ktime = ring_time[rd_ptr];
        rd_ptr++;
      end
      OP_PEEK: if (rd_ptr != wr_ptr) r.word = ring_word[rd_ptr];
      OP_RD_DOWN: begin
        r.cnt = make_cnt[c.code];
        make_cnt[c.code] = '0;
      end
      OP_RD_UP: begin
        r.cnt = break_cnt[c.code];
        break_cnt[c.code] = '0;
      end
      OP_FLUSH: clear_queue_state();
      OP_FWRITE: accept_tab[c.fidx] = c.fval;
      default: clear_accept_tab();
    endcase
    r.nonempty = (rd_ptr != wr_ptr);
    return r;
  endfunction

  function automatic kbq_cmd_t mk(opcode_e op, logic [7:0] code, logic dn,
                                  logic [31:0] t, logic [5:0] fi, logic [15:0] fv,
                                  bit fixed = 1'b0, kbq_res_t res = '0);
    kbq_cmd_t c;
    c.op = op; c.code = code; c.dn = dn; c.t = t; c.fidx = fi; c.fval = fv;
    c.fixed = fixed; c.res = res;
    return c;
  endfunction

  task automatic send_cmd(kbq_cmd_t c);
    kbq_res_t r;
    while (!quiet && $urandom_range(99) < 25) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, c.fval, c.fidx, c.t, c.dn, c.code, c.op};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_result(c);
    result_q.push_back(c.fixed ? c.res : r);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    // further idle time before the next phase
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_REPEAT: rpt_en = val[0];
      CFG_LAYOUT: layout = val[1:0];
      CFG_FCOUNT: flt_cnt = val[6:0];
      default: dbg_en = val[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic rand_cmd(int pop_pct);
    kbq_cmd_t c;
    int       p;
    c = mk(OP_KEY, 8'($urandom), 1'($urandom), $urandom, 6'($urandom), 16'($urandom));
    p = $urandom_range(99);
    if (p < 50) begin
      c.op = OP_KEY;
      if ($urandom_range(3) != 0) c.code = hot_codes[$urandom_range(21)];
      c.dn = ($urandom_range(99) < 55);
    end else if (p < 50 + pop_pct) c.op = OP_POP;
    else if (p < 80) c.op = opcode_e'($urandom_range(2, 4));
    else if (p < 82) c.op = OP_FLUSH;
    else if (p < 97) begin
      c.op = OP_FWRITE;
      if ($urandom_range(1)) c.fval = {$urandom_range(1) ? 4'h1 : 4'h0, 4'h0,
                                       hot_codes[$urandom_range(21)]};
    end else c.op = OP_FCLEAR;
    if (c.op inside {OP_RD_DOWN, OP_RD_UP} && $urandom_range(1))
      c.code = hot_codes[$urandom_range(21)];
    send_cmd(c);
  endtask

  always @(negedge clk_i) m_axis_tready <= quiet || ($urandom_range(99) >= 25);

  always @(posedge clk_i) begin
    kbq_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.word     = m_axis_tdata[15:0];
      got.ktime    = m_axis_tdata[47:16];
      got.cnt      = m_axis_tdata[63:48];
      got.nonempty = m_axis_tdata[64];
      got.acc      = m_axis_tdata[65];
      if (result_q.size() == 0) begin
        $display("%0t: result exp none got %h", $time, got);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.word !== want.word)
          $display("%0t: key_word exp %h got %h", $time, want.word, got.word);
        if (got.ktime !== want.ktime)
          $display("%0t: key_time exp %h got %h", $time, want.ktime, got.ktime);
        if (got.cnt !== want.cnt)
          $display("%0t: edge_count exp %h got %h", $time, want.cnt, got.cnt);
        if (got.nonempty !== want.nonempty)
          $display("%0t: queue_nonempty exp %b got %b", $time, want.nonempty, got.nonempty);
        if (got.acc !== want.acc)
          $display("%0t: accepted exp %b got %b", $time, want.acc, got.acc);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    #50ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    kbq_cmd_t dir_tab[$];
    logic [7:0] cfg_set [6][4] = '{'{1, 0, 0, 1}, '{0, 1, 0, 0}, '{1, 2, 64, 1},
                                   '{0, 3, 127, 1}, '{1, 1, 5, 0}, '{0, 0, 1, 1}};
    rpt_en = 1'b1; dbg_en = 1'b1; layout = '0;
    clear_queue_state();
    clear_accept_tab();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    dir_tab.push_back(mk(OP_POP, 8'h00, 0, 0, 0, 0, 1, '0));
    dir_tab.push_back(mk(OP_PEEK, 8'hFF, 1, 32'hFFFF_FFFF, 63, 16'hFFFF, 1, '0));
    dir_tab.push_back(mk(OP_RD_DOWN, 8'hFF, 0, 0, 0, 0, 1, '0));
    dir_tab.push_back(mk(OP_KEY, ScNoBuf, 1, 32'h1, 0, 0, 1, '0));
    dir_tab.push_back(mk(OP_KEY, 8'h00, 1, 32'h2, 0, 0, 1, '0));
    dir_tab.push_back(mk(OP_KEY, ScRShift, 1, 32'h10, 0, 0));
    dir_tab.push_back(mk(OP_KEY, 8'h1E, 1, 32'h20, 0, 0));
    dir_tab.push_back(mk(OP_KEY, ScDebug, 1, 32'h30, 0, 0));
    dir_tab.push_back(mk(OP_KEY, ScLCtrl, 1, 32'h40, 0, 0));
    dir_tab.push_back(mk(OP_KEY, ScRAlt, 1, 32'h50, 0, 0));
    dir_tab.push_back(mk(OP_KEY, 8'h56, 1, 32'h60, 0, 0));
    dir_tab.push_back(mk(OP_KEY, 8'hFF, 1, 32'hFFFF_FFFF, 0, 0));
    dir_tab.push_back(mk(OP_KEY, 8'hFF, 1, 32'h0, 0, 0));
    dir_tab.push_back(mk(OP_POP, 8'h00, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_PEEK, 8'h00, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_KEY, ScRShift, 0, 32'h70, 0, 0));
    dir_tab.push_back(mk(OP_RD_UP, ScLShift, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_RD_DOWN, ScLShift, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_FWRITE, 8'h00, 0, 0, 63, 16'h0000));
    dir_tab.push_back(mk(OP_FWRITE, 8'h00, 0, 0, 0, 16'hFFFF));
    dir_tab.push_back(mk(OP_FCLEAR, 8'h00, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_FLUSH, 8'h00, 0, 0, 0, 0, 1, '0));
    dir_tab.push_back(mk(OP_POP, 8'h00, 0, 0, 0, 0, 1, '0));
    foreach (dir_tab[i]) send_cmd(dir_tab[i]);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      for (int r = 0; r < 4; r++) write_reg(cfg_reg_e'(r), cfg_set[ph][r]);
      if (cfg_set[ph][2] != 0)
        for (int i = 0; i < 8; i++)
          send_cmd(mk(OP_FWRITE, 0, 0, $urandom, i[5:0],
                      {$urandom_range(1) ? 4'h1 : 4'h0, 4'h0, hot_codes[$urandom_range(21)]}));
      quiet = (ph == 2);
      for (int i = 0; i < 300; i++) rand_cmd((ph == 3) ? 5 : 20);
      quiet = 1'b0;
    end

    drain();
    if (errors == 0 && result_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/kbq_pkg.sv
rtl/core/kbq_filter.sv
rtl/core/keyboard_event_queue_top.sv
dv/tb.sv
